FILE: rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mi3_pkg;

   // Default element format: signed Q16.16
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ELEM_WIDTH_DEF = 32;

   // Matrix elements per transfer
   localparam int N_ELEM = 9;

   // Singular threshold register, in units of 2^-(3*FRAC_BITS)
   localparam int               THR_WIDTH = 41;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 41'd33554432;

   // Per-lane status traveling beside the quotient
   typedef struct packed {
      logic valid;
      logic ovf;
      logic neg;
   } lane_flags_type;

endpackage

`default_nettype wire

FILE: rtl/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: threshold register,
// sign/magnitude stage, nine divider lanes and the merging output stage.
// Depends on mi3_pkg, mi3_adj_det and mi3_div_lane.
//
// Usage:
//   Input: drive the nine req_in_* elements (signed, column by column) and
//   raise start; the matrix transfers at a clock edge with start high and
//   busy low. busy stays low, so a matrix may transfer on every cycle.
//   Output: rsp_strobe is high for one cycle per matrix, with the nine
//   rsp_out_* elements, rsp_determinant and rsp_ok. The receiver cannot
//   stall; every result must be taken in the cycle it is shown.
//   Path: adjugate/determinant pipeline, sign/magnitude registers, divider
//   lanes and output register. Throughput: one matrix per cycle, set by the
//   fully pipelined divider lanes that produce one quotient bit per stage.
//   Singular matrices (|det| below csr_wdata threshold or det zero) come back
//   unchanged with rsp_ok low, at the same latency as other matrices.
//   Config: csr_we writes csr_wdata into the singular threshold; write only
//   while no matrix is in flight.
//   Reset: synchronous, clears all in-flight items and restores the
//   threshold to its default.
`default_nettype none

module matrix3x3_inverse #(
   parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF,
   parameter int ELEMENT_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r0c0,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r1c0,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r2c0,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r0c1,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r1c1,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r2c1,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r0c2,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r1c2,
   input  wire logic signed [ELEMENT_WIDTH-1:0]   req_in_r2c2,
   output logic                                   rsp_strobe,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r0c0,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r1c0,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r2c0,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r0c1,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r1c1,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r2c1,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r0c2,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r1c2,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_out_r2c2,
   output logic signed [ELEMENT_WIDTH-1:0]        rsp_determinant,
   output logic                                   rsp_ok,
   input  wire logic                              csr_we,
   input  wire logic [mi3_pkg::THR_WIDTH-1:0]     csr_wdata
);
   import mi3_pkg::*;

   localparam int EW  = ELEMENT_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int MW  = 2 * EW + 1;
   localparam int DW  = 3 * EW + 3;
   localparam int LAT = EW + 2;   // divider lane latency

   localparam logic [DW:0]   HALF    = (DW+1)'(1) << (2 * FB - 1);
   localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

   logic [THR_WIDTH-1:0]   thr_ff;

   logic                   in_valid;
   logic signed [EW-1:0]   a_in  [N_ELEM];
   logic                   fd_valid;
   logic signed [EW-1:0]   fd_a  [N_ELEM];
   logic signed [MW-1:0]   fd_adj[N_ELEM];
   logic signed [DW-1:0]   fd_det;

   logic                   dneg;
   logic [DW-1:0]          dmag;
   logic signed [DW:0]     det_rnd;
   logic [EW-1:0]          det_sat;

   logic                   v6_ff;
   logic [DW-1:0]          dmag6_ff;
   logic                   sing6_ff;
   logic [EW-1:0]          detq6_ff;
   logic [MW-1:0]          mag6_ff [N_ELEM];
   logic                   neg6_ff [N_ELEM];
   logic signed [EW-1:0]   a6_ff   [N_ELEM];

   logic signed [EW-1:0]   side_a_ff  [LAT][N_ELEM];
   logic                   side_sing_ff [LAT];
   logic [EW-1:0]          side_det_ff  [LAT];

   lane_flags_type         lane_flags [N_ELEM];
   logic [EW-1:0]          lane_quot  [N_ELEM];
   logic [EW-1:0]          elem_in    [N_ELEM];

   logic                   strobe_ff;
   logic                   ok_ff;
   logic [EW-1:0]          det_ff;
   logic [EW-1:0]          elem_ff    [N_ELEM];

   // Every cycle can take a transfer
   assign busy     = 1'b0;
   assign in_valid = start & ~busy;

   assign a_in[0] = req_in_r0c0;
   assign a_in[1] = req_in_r1c0;
   assign a_in[2] = req_in_r2c0;
   assign a_in[3] = req_in_r0c1;
   assign a_in[4] = req_in_r1c1;
   assign a_in[5] = req_in_r2c1;
   assign a_in[6] = req_in_r0c2;
   assign a_in[7] = req_in_r1c2;
   assign a_in[8] = req_in_r2c2;

   // Singular threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   mi3_adj_det #(.EW(EW)) u_adj_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .a_in      (a_in),
      .out_valid (fd_valid),
      .a_out     (fd_a),
      .adj_out   (fd_adj),
      .det_out   (fd_det)
   );

   // Determinant sign, magnitude and rounded Q output
   always_comb begin
      dneg    = fd_det[DW-1];
      dmag    = dneg ? DW'(-fd_det) : DW'(fd_det);
      det_rnd = ($signed({fd_det[DW-1], fd_det}) + $signed(HALF)) >>> (2 * FB);
      if (&det_rnd[DW:EW-1] || ~|det_rnd[DW:EW-1]) begin
         det_sat = det_rnd[EW-1:0];
      end else begin
         det_sat = det_rnd[DW] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= fd_valid;
      end
   end

   always_ff @(posedge clock) begin
      dmag6_ff <= dmag;
      sing6_ff <= (fd_det == '0) || (dmag < DW'(thr_ff));
      detq6_ff <= det_sat;
      for (int i = 0; i < N_ELEM; i++) begin
         mag6_ff[i] <= fd_adj[i][MW-1] ? MW'(-fd_adj[i]) : MW'(fd_adj[i]);
         neg6_ff[i] <= fd_adj[i][MW-1] ^ dneg;
         a6_ff[i]   <= fd_a[i];
      end
   end

   // Divider lanes, one per element
   for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
      mi3_div_lane #(.EW(EW), .FB(FB)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v6_ff),
         .in_neg    (neg6_ff[i]),
         .in_mag    (mag6_ff[i]),
         .in_dmag   (dmag6_ff),
         .out_flags (lane_flags[i]),
         .out_quot  (lane_quot[i])
      );
   end

   // Side data aligned with the lanes
   always_ff @(posedge clock) begin
      side_a_ff[0]    <= a6_ff;
      side_sing_ff[0] <= sing6_ff;
      side_det_ff[0]  <= detq6_ff;
      for (int s = 1; s < LAT; s++) begin
         side_a_ff[s]    <= side_a_ff[s-1];
         side_sing_ff[s] <= side_sing_ff[s-1];
         side_det_ff[s]  <= side_det_ff[s-1];
      end
   end

   // Merge: saturate and sign each quotient, or pass the matrix through
   always_comb begin
      for (int i = 0; i < N_ELEM; i++) begin
         if (side_sing_ff[LAT-1]) begin
            elem_in[i] = side_a_ff[LAT-1][i];
         end else if (lane_flags[i].neg) begin
            if (lane_flags[i].ovf || lane_quot[i] > SAT_MIN) begin
               elem_in[i] = SAT_MIN;
            end else begin
               elem_in[i] = EW'(-lane_quot[i]);
            end
         end else if (lane_flags[i].ovf || lane_quot[i][EW-1]) begin
            elem_in[i] = SAT_MAX;
         end else begin
            elem_in[i] = lane_quot[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= lane_flags[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ~side_sing_ff[LAT-1];
      det_ff  <= side_det_ff[LAT-1];
      elem_ff <= elem_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_determinant = det_ff;
   assign rsp_out_r0c0    = elem_ff[0];
   assign rsp_out_r1c0    = elem_ff[1];
   assign rsp_out_r2c0    = elem_ff[2];
   assign rsp_out_r0c1    = elem_ff[3];
   assign rsp_out_r1c1    = elem_ff[4];
   assign rsp_out_r2c1    = elem_ff[5];
   assign rsp_out_r0c2    = elem_ff[6];
   assign rsp_out_r1c2    = elem_ff[7];
   assign rsp_out_r2c2    = elem_ff[8];

`ifndef SYNTHESIS
   // Each transfer yields exactly one result after the fixed latency
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ELEMENT_WIDTH + 9) rsp_strobe)
      else $error("result missing after transfer");

   a_latency_bwd : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, ELEMENT_WIDTH + 9))
      else $error("result without matching transfer");

   // The last lane advances in lockstep with the first
   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      lane_flags[0].valid == lane_flags[8].valid)
      else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

FILE: rtl/mi3_adj_det.sv
// Adjugate and determinant pipeline: 2x2 minors, then cofactor expansion.
// Depends on mi3_pkg. Five register stages, one matrix per cycle.
`default_nettype none

module mi3_adj_det #(
   parameter int EW = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [EW-1:0]       a_in    [mi3_pkg::N_ELEM],
   output logic                            out_valid,
   output logic signed [EW-1:0]            a_out   [mi3_pkg::N_ELEM],
   output logic signed [2*EW:0]            adj_out [mi3_pkg::N_ELEM],
   output logic signed [3*EW+2:0]          det_out
);
   import mi3_pkg::*;

   localparam int MW = 2 * EW + 1;   // minor width
   localparam int PW = 3 * EW + 1;   // one expansion term
   localparam int DW = 3 * EW + 3;   // determinant

   // adj[i] = a[t0]*a[t1] - a[t2]*a[t3]; elements are indexed column-major
   localparam int MINOR_TAB [0:8][0:3] = '{
      '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{6, 5, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   logic [4:0]               vld_ff;
   logic signed [2*EW-1:0]   p1_ff   [N_ELEM];
   logic signed [2*EW-1:0]   q1_ff   [N_ELEM];
   logic signed [EW-1:0]     a1_ff   [N_ELEM];
   logic signed [MW-1:0]     adj2_ff [N_ELEM];
   logic signed [EW-1:0]     a2_ff   [N_ELEM];
   logic signed [2*EW+1:0]   lo3_ff  [3];
   logic signed [2*EW-1:0]   hi3_ff  [3];
   logic signed [MW-1:0]     adj3_ff [N_ELEM];
   logic signed [EW-1:0]     a3_ff   [N_ELEM];
   logic signed [PW-1:0]     term4_ff[3];
   logic signed [MW-1:0]     adj4_ff [N_ELEM];
   logic signed [EW-1:0]     a4_ff   [N_ELEM];
   logic signed [DW-1:0]     det5_ff;
   logic signed [MW-1:0]     adj5_ff [N_ELEM];
   logic signed [EW-1:0]     a5_ff   [N_ELEM];

   // Valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // Stage 1: minor products; stage 2: minors
   always_ff @(posedge clock) begin
      for (int i = 0; i < N_ELEM; i++) begin
         p1_ff[i]   <= a_in[MINOR_TAB[i][0]] * a_in[MINOR_TAB[i][1]];
         q1_ff[i]   <= a_in[MINOR_TAB[i][2]] * a_in[MINOR_TAB[i][3]];
         a1_ff[i]   <= a_in[i];
         adj2_ff[i] <= {p1_ff[i][2*EW-1], p1_ff[i]} - {q1_ff[i][2*EW-1], q1_ff[i]};
         a2_ff[i]   <= a1_ff[i];
      end
   end

   // Stage 3: row-0 expansion, each minor split into low and high partial products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         lo3_ff[k] <= a2_ff[3*k] * $signed({1'b0, adj2_ff[k][EW:0]});
         hi3_ff[k] <= a2_ff[3*k] * $signed(adj2_ff[k][MW-1:EW+1]);
      end
      adj3_ff <= adj2_ff;
      a3_ff   <= a2_ff;
   end

   // Stage 4: recombine partials; stage 5: sum of the three terms
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         term4_ff[k] <= {hi3_ff[k], {(EW+1){1'b0}}}
                      + {{(EW-1){lo3_ff[k][2*EW+1]}}, lo3_ff[k]};
      end
      adj4_ff <= adj3_ff;
      a4_ff   <= a3_ff;
      det5_ff <= {{2{term4_ff[0][PW-1]}}, term4_ff[0]}
               + {{2{term4_ff[1][PW-1]}}, term4_ff[1]}
               + {{2{term4_ff[2][PW-1]}}, term4_ff[2]};
      adj5_ff <= adj4_ff;
      a5_ff   <= a4_ff;
   end

   assign out_valid = vld_ff[4];
   assign a_out     = a5_ff;
   assign adj_out   = adj5_ff;
   assign det_out   = det5_ff;

endmodule

`default_nettype wire

FILE: rtl/mi3_div_lane.sv
// One divider lane: rounded |adj| * 2^(2F) / |det|, one quotient bit per stage.
// Depends on mi3_pkg. Operand and overflow registers ahead of the bit stages; one operand pair per cycle.
`default_nettype none

module mi3_div_lane #(
   parameter int EW = 32,
   parameter int FB = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic                   in_neg,
   input  wire logic [2*EW:0]          in_mag,
   input  wire logic [3*EW+2:0]        in_dmag,
   output mi3_pkg::lane_flags_type     out_flags,
   output logic [EW-1:0]               out_quot
);
   import mi3_pkg::*;

   localparam int RW = 4 * EW + 2 * FB + 6;   // remainder, covers numerator and D<<EW

   logic            v0_ff;
   logic            neg0_ff;
   logic [RW-1:0]   n0_ff;
   logic [RW-1:0]   d0_ff;

   logic            vld_ff [0:EW];
   logic            ovf_ff [0:EW];
   logic            neg_ff [0:EW];
   logic [RW-1:0]   rem_ff [0:EW];
   logic [RW-1:0]   d_ff   [0:EW];
   logic [EW-1:0]   q_ff   [0:EW];

   // Control: valid through the operand stage; the bit stages carry it on below
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         v0_ff     <= in_valid;
         vld_ff[0] <= v0_ff;
      end
   end

   // Operands: numerator 2*|adj|*2^(2F) + |det| over denominator 2*|det| rounds half away
   always_ff @(posedge clock) begin
      neg0_ff    <= in_neg;
      n0_ff      <= (RW'(in_mag) << (2 * FB + 1)) + RW'(in_dmag);
      d0_ff      <= RW'(in_dmag) << 1;
      // quotient of more than EW bits saturates anyway
      ovf_ff[0]  <= n0_ff >= (d0_ff << EW);
      neg_ff[0]  <= neg0_ff;
      rem_ff[0]  <= n0_ff;
      d_ff[0]    <= d0_ff;
      q_ff[0]    <= '0;
   end

   // Restoring division, MSB first
   for (genvar s = 0; s < EW; s++) begin : g_step
      localparam int BIT = EW - 1 - s;
      logic [RW-1:0] dsh;
      logic          take;

      assign dsh  = d_ff[s] << BIT;
      assign take = rem_ff[s] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= take ? rem_ff[s] - dsh : rem_ff[s];
         q_ff[s+1]   <= {q_ff[s][EW-2:0], take};
         d_ff[s+1]   <= d_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   assign out_flags.valid = vld_ff[EW];
   assign out_flags.ovf   = ovf_ff[EW];
   assign out_flags.neg   = neg_ff[EW];
   assign out_quot        = q_ff[EW];

endmodule

`default_nettype wire

FILE: tb/sv/matrix3x3_inverse_tb.sv
// Self-checking testbench for matrix3x3_inverse: directed and random matrices
// against an exact wide-integer predictor of inverse, determinant and rsp_ok.
// Depends on mi3_pkg and the matrix3x3_inverse RTL.
`timescale 1ns / 100ps

module matrix3x3_inverse_tb;
   import mi3_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int EW = ELEM_WIDTH_DEF;
   localparam int LATENCY = EW + 9;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [191:0] wide_type;
   typedef struct { elem_type m[N_ELEM]; } matrix_type;
   typedef struct { elem_type m[N_ELEM]; elem_type det; logic ok; } inverse_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   elem_type req_elem[N_ELEM] = '{default: '0};
   logic csr_we = 0;
   logic [THR_WIDTH-1:0] csr_wdata = '0;
   logic rsp_strobe, rsp_ok;
   elem_type rsp_elem[N_ELEM];
   elem_type rsp_determinant;

   matrix_type pending_mats[$];
   inverse_type expected_inv[$];
   logic [THR_WIDTH-1:0] thr_shadow = THR_RESET;
   int idle_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   matrix3x3_inverse uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_r0c0(req_elem[0]), .req_in_r1c0(req_elem[1]), .req_in_r2c0(req_elem[2]),
      .req_in_r0c1(req_elem[3]), .req_in_r1c1(req_elem[4]), .req_in_r2c1(req_elem[5]),
      .req_in_r0c2(req_elem[6]), .req_in_r1c2(req_elem[7]), .req_in_r2c2(req_elem[8]),
      .rsp_strobe(rsp_strobe),
      .rsp_out_r0c0(rsp_elem[0]), .rsp_out_r1c0(rsp_elem[1]), .rsp_out_r2c0(rsp_elem[2]),
      .rsp_out_r0c1(rsp_elem[3]), .rsp_out_r1c1(rsp_elem[4]), .rsp_out_r2c1(rsp_elem[5]),
      .rsp_out_r0c2(rsp_elem[6]), .rsp_out_r1c2(rsp_elem[7]), .rsp_out_r2c2(rsp_elem[8]),
      .rsp_determinant(rsp_determinant), .rsp_ok(rsp_ok),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Clamp a wide value to the signed element range
   function automatic elem_type clamp_elem(wide_type v);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (EW - 1)) - 1;
      lo = -(wide_type'(1) <<< (EW - 1));
      if (v > hi) return hi[EW-1:0];
      if (v < lo) return lo[EW-1:0];
      return v[EW-1:0];
   endfunction

   // Exact inverse: cofactors, determinant, rounded quotient per element; a singular matrix comes back unchanged
   function automatic inverse_type invert_matrix(matrix_type x, logic [THR_WIDTH-1:0] thr);
      int cof_idx[9][4] = '{'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                            '{6, 5, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                            '{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
      wide_type a[N_ELEM];
      wide_type adj[N_ELEM];
      wide_type det, dmag, num;
      logic [191:0] umag, uden, uq;
      logic neg;
      inverse_type r;
      for (int i = 0; i < N_ELEM; i++) a[i] = wide_type'(x.m[i]);
      for (int i = 0; i < N_ELEM; i++)
         adj[i] = a[cof_idx[i][0]] * a[cof_idx[i][1]] - a[cof_idx[i][2]] * a[cof_idx[i][3]];
      det = a[0] * adj[0] + a[3] * adj[1] + a[6] * adj[2];
      dmag = (det < 0) ? -det : det;
      r.det = clamp_elem((det + (wide_type'(1) <<< (2 * FB - 1))) >>> (2 * FB));
      if (det == 0 || dmag < wide_type'({1'b0, thr})) begin
         r.m = x.m;
         r.ok = 1'b0;
         return r;
      end
      for (int i = 0; i < N_ELEM; i++) begin
         num = adj[i] <<< (2 * FB);
         neg = (num < 0) != (det < 0);
         umag = ((num < 0) ? -num : num);
         umag = (umag << 1) + dmag;
         uden = dmag << 1;
         uq = umag / uden;
         r.m[i] = clamp_elem(neg ? -wide_type'(uq) : wide_type'(uq));
      end
      r.ok = 1'b1;
      return r;
   endfunction

   function automatic elem_type rand_elem(int kind);
      case (kind)
         0: return elem_type'($urandom);
         1: return elem_type'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         default: return elem_type'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      endcase
   endfunction

   // Random matrix: full-range bits, modest values, singular and near-singular, diagonal
   function automatic matrix_type rand_matrix();
      matrix_type x;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < N_ELEM; i++) x.m[i] = rand_elem(kind < 2 ? 0 : 1);
      if (kind >= 6 && kind <= 8) begin
         // row 2 = row 0 + row 1, then a small nudge unless kind is 6
         for (int c = 0; c < 3; c++) begin
            x.m[3*c] = rand_elem(2);
            x.m[3*c+1] = rand_elem(2);
            x.m[3*c+2] = x.m[3*c] + x.m[3*c+1];
         end
         if (kind != 6) x.m[$urandom_range(0, 8)] += elem_type'($urandom_range(0, 8)) - 4;
      end else if (kind == 9) begin
         for (int i = 0; i < N_ELEM; i++)
            if (i % 4 != 0) x.m[i] = '0;
            else x.m[i] = elem_type'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      end
      return x;
   endfunction

   function automatic matrix_type diag_matrix(elem_type d0, elem_type d1, elem_type d2);
      matrix_type x;
      x.m = '{default: '0};
      x.m[0] = d0;
      x.m[4] = d1;
      x.m[8] = d2;
      return x;
   endfunction

   task automatic queue_directed();
      matrix_type x;
      elem_type one, emax, emin;
      one = elem_type'(1) <<< FB;
      emax = {1'b0, {(EW-1){1'b1}}};
      emin = {1'b1, {(EW-1){1'b0}}};
      x.m = '{default: '0};
      pending_mats.push_back(x);
      pending_mats.push_back(diag_matrix(one, one, one));
      pending_mats.push_back(diag_matrix(-one, one, one));
      pending_mats.push_back(diag_matrix(one <<< 1, one >>> 1, -(one <<< 3)));
      // threshold boundary: det of exactly the threshold and one below
      pending_mats.push_back(diag_matrix(1, 1, 33554432));
      pending_mats.push_back(diag_matrix(1, 1, 33554431));
      pending_mats.push_back(diag_matrix(-1, 1, 33554432));
      // small diagonal entries: inverse is large but within range
      pending_mats.push_back(diag_matrix(1 <<< 12, 1 <<< 12, 1 <<< 12));
      pending_mats.push_back(diag_matrix(-(1 <<< 12), 1 <<< 12, 1 <<< 12));
      pending_mats.push_back(diag_matrix(emax, emax, emax));
      pending_mats.push_back(diag_matrix(emin, emin, emin));
      pending_mats.push_back(diag_matrix(emin, emax, emin));
      x.m = '{default: emax};
      pending_mats.push_back(x);
      x.m = '{default: emin};
      pending_mats.push_back(x);
      x.m = '{emax, emin, emax, emin, emax, emin, emax, emin, emax};
      pending_mats.push_back(x);
      x.m = '{emin, emax, 0, emax, 0, emin, 0, emin, emax};
      pending_mats.push_back(x);
      x.m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 10*one};
      pending_mats.push_back(x);
      x.m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
      pending_mats.push_back(x);
      x.m = '{0, one, 0, 0, 0, one, one, 0, 0};
      pending_mats.push_back(x);
      x.m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      pending_mats.push_back(x);
   endtask

   task automatic run_phase(int n, int idle);
      idle_pct = idle;
      for (int i = 0; i < n; i++) pending_mats.push_back(rand_matrix());
      wait (pending_mats.size() == 0 && expected_inv.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_WIDTH-1:0] thr);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = thr;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Sequence: reset, directed sets and random phases under several thresholds
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      queue_directed();
      run_phase(250, 0);
      write_threshold('0);
      queue_directed();
      run_phase(300, 74);
      write_threshold(41'd1 << 40);
      run_phase(250, 0);
      write_threshold(THR_WIDTH'({$urandom, $urandom}) % (41'd1 << 30));
      run_phase(250, 16);
      write_threshold(THR_RESET);
      run_phase(250, 74);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Driver: present the head of the pending queue, with random idle cycles
   always @(negedge clock) begin
      if (!reset && pending_mats.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
         start <= 1'b1;
         req_elem <= pending_mats[0].m;
      end else begin
         start <= 1'b0;
      end
   end

   // Transfer on the request side: predict and retire the item
   always @(posedge clock) begin
      if (csr_we) thr_shadow <= csr_wdata;
      if (!reset && start && !busy) begin
         expected_inv.push_back(invert_matrix(pending_mats[0], thr_shadow));
         void'(pending_mats.pop_front());
      end
   end

   // Monitor: compare each result against the oldest prediction
   always @(posedge clock) begin
      inverse_type e;
      if (!reset && rsp_strobe) begin
         if (expected_inv.size() == 0) begin
            $display("%0t: unexpected result, nothing pending", $time);
            errors = errors + 1;
         end else begin
            e = expected_inv.pop_front();
            for (int i = 0; i < N_ELEM; i++)
               if (rsp_elem[i] !== e.m[i]) begin
                  $display("%0t: element %0d expected %0d got %0d",
                           $time, i, e.m[i], rsp_elem[i]);
                  errors = errors + 1;
               end
            if (rsp_determinant !== e.det) begin
               $display("%0t: determinant expected %0d got %0d",
                        $time, e.det, rsp_determinant);
               errors = errors + 1;
            end
            if (rsp_ok !== e.ok) begin
               $display("%0t: ok expected %0b got %0b", $time, e.ok, rsp_ok);
               errors = errors + 1;
            end
         end
      end
   end

   // Watchdog: stop if no transfer or result happens for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/mi3_pkg.sv
rtl/mi3_adj_det.sv
rtl/mi3_div_lane.sv
rtl/matrix3x3_inverse.sv
tb/sv/matrix3x3_inverse_tb.sv
